FILE: sv/lzmc_pkg.sv
`timescale 1ns / 1ps

package lzmc_pkg;

    localparam int BYTE_W = 8;
    localparam int OFF_W  = 16;
    localparam int LEN_W  = 7;
    localparam int PROD_W = 17;
    localparam int REQ_W  = 2;

    localparam logic [PROD_W-1:0] PROD_MAX = {PROD_W{1'b1}};

    localparam logic [REQ_W-1:0] REQ_BLOCK   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LITERAL = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MATCH   = 2'd2;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        CMD_LIT  = 2'd0,
        CMD_COPY = 2'd1,
        CMD_ERR  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [BYTE_W-1:0]   lit;
        logic [OFF_W-1:0]    offset;
        logic [LEN_W-1:0]    len;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_push_t;

endpackage

FILE: sv/lzmc_ram.sv
`timescale 1ns / 1ps

module lzmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/lzmc_front.sv
`timescale 1ns / 1ps

module lzmc_front
    import lzmc_pkg::*;
#(
    parameter int WINDOW    = 65536,
    parameter int MAX_CHUNK = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [BYTE_W-1:0]   literal_byte,
    input  logic [OFF_W-1:0]    match_offset,
    input  logic [LEN_W-1:0]    chunk_len,
    input  logic                q_full,
    output cmd_push_t           push
);

    localparam logic [LEN_W-1:0]  CHUNK_MAX = LEN_W'(MAX_CHUNK);
    localparam logic [PROD_W-1:0] WIN_LIM   = PROD_W'(WINDOW);

    logic [PROD_W-1:0] produced_reg;
    logic [PROD_W-1:0] produced_next;
    logic              accept;
    logic [LEN_W-1:0]  len_sat;
    logic              bad_offset;
    logic [PROD_W:0]   prod_sum;
    logic [PROD_W-1:0] prod_inc;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign len_sat  = (chunk_len > CHUNK_MAX) ? CHUNK_MAX : chunk_len;

    assign bad_offset = (match_offset == '0)
                     || ({1'b0, match_offset} > produced_reg)
                     || ({1'b0, match_offset} > WIN_LIM);

    assign prod_sum = {1'b0, produced_reg} + {1'b0, prod_inc};

    always_comb
    begin
        push            = '0;
        push.cmd.lit    = literal_byte;
        push.cmd.offset = match_offset;
        push.cmd.len    = len_sat;
        push.cmd.kind   = CMD_LIT;
        prod_inc        = '0;
        produced_next   = produced_reg;
        if (accept)
        begin
            case (req_type)
                REQ_BLOCK:
                begin
                    produced_next = '0;
                end
                REQ_LITERAL:
                begin
                    push.valid = 1'b1;
                    prod_inc   = PROD_W'(1);
                end
                REQ_MATCH:
                begin
                    if (chunk_len != '0)
                    begin
                        push.valid = 1'b1;
                        if (bad_offset)
                        begin
                            push.cmd.kind = CMD_ERR;
                        end
                        else
                        begin
                            push.cmd.kind = CMD_COPY;
                            prod_inc      = PROD_W'(len_sat);
                        end
                    end
                end
                default:
                begin
                    push.valid = 1'b0;
                end
            endcase
            if (req_type != REQ_BLOCK)
            begin
                produced_next = (prod_sum > {1'b0, PROD_MAX}) ? PROD_MAX
                                                              : prod_sum[PROD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            produced_reg <= '0;
        end
        else
        begin
            produced_reg <= produced_next;
        end
    end

endmodule

FILE: sv/lzmc_fifo.sv
`timescale 1ns / 1ps

module lzmc_fifo
    import lzmc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_push_t push,
    output logic      full,
    input  logic      pop,
    output logic      empty,
    output cmd_t      head
);

    cmd_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;
    logic           do_push;
    logic           do_pop;

    assign full    = (count_reg == (QAW+1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (QAW+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (QAW+1)'(1);
            end
        end
    end

endmodule

FILE: sv/lzmc_back.sv
`timescale 1ns / 1ps

module lzmc_back
    import lzmc_pkg::*;
#(
    parameter int WINDOW = 65536
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  cmd_t              q_head,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              out_last,
    output logic              out_error
);

    localparam int AW = $clog2(WINDOW);
    localparam logic [AW:0]   WIN     = (AW+1)'(WINDOW);
    localparam logic [AW-1:0] WP_LAST = AW'(WINDOW - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_READ  = 3'b010,
        ST_WRITE = 3'b100
    } back_state_t;

    back_state_t       state_reg, state_next;
    logic [AW-1:0]     wp_reg, wp_next;
    logic [AW:0]       dist_reg, dist_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic              ovalid_reg, ovalid_next;
    logic [BYTE_W-1:0] obyte_reg, obyte_next;
    logic              olast_reg, olast_next;
    logic              oerr_reg, oerr_next;

    logic              out_free;
    logic              ram_we;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_wdata;
    logic [BYTE_W-1:0] ram_rdata;
    logic [AW:0]       src_sum;
    logic [AW:0]       src_wrap;
    logic [AW-1:0]     wp_inc;

    lzmc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WINDOW)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (src_wrap[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign out_free  = !ovalid_reg || out_ready;
    assign src_sum   = {1'b0, wp_reg} + dist_reg;
    assign src_wrap  = (src_sum >= WIN) ? (src_sum - WIN) : src_sum;
    assign wp_inc    = (wp_reg == WP_LAST) ? '0 : (wp_reg + AW'(1));

    always_comb
    begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        dist_next   = dist_reg;
        rem_next    = rem_reg;
        ovalid_next = ovalid_reg && !out_ready;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        oerr_next   = oerr_reg;
        q_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_wdata   = q_head.lit;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_head.kind)
                        CMD_LIT:
                        begin
                            if (out_free)
                            begin
                                q_pop       = 1'b1;
                                ram_we      = 1'b1;
                                wp_next     = wp_inc;
                                ovalid_next = 1'b1;
                                obyte_next  = q_head.lit;
                                olast_next  = 1'b1;
                                oerr_next   = 1'b0;
                            end
                        end
                        CMD_ERR:
                        begin
                            if (out_free)
                            begin
                                q_pop       = 1'b1;
                                ovalid_next = 1'b1;
                                obyte_next  = '0;
                                olast_next  = 1'b1;
                                oerr_next   = 1'b1;
                            end
                        end
                        CMD_COPY:
                        begin
                            q_pop      = 1'b1;
                            dist_next  = WIN - (AW+1)'(q_head.offset);
                            rem_next   = q_head.len;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                ram_wdata = ram_rdata;
                if (out_free)
                begin
                    ram_we      = 1'b1;
                    wp_next     = wp_inc;
                    rem_next    = rem_reg - LEN_W'(1);
                    ovalid_next = 1'b1;
                    obyte_next  = ram_rdata;
                    olast_next  = (rem_reg == LEN_W'(1));
                    oerr_next   = 1'b0;
                    state_next  = (rem_reg == LEN_W'(1)) ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wp_reg     <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg  <= dist_next;
        rem_reg   <= rem_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
        oerr_reg  <= oerr_next;
    end

    assign out_valid = ovalid_reg;
    assign out_byte  = obyte_reg;
    assign out_last  = olast_reg;
    assign out_error = oerr_reg;

endmodule

FILE: sv/lz4_match_copy_engine.sv
`timescale 1ns / 1ps
// LZ4 match copy engine: executes decoded LZ4 sequences into a byte stream.
// s_axis: one command per transaction. tuser carries the kind (block start,
// literal, match chunk); tdata carries literal byte, match offset and length.
// m_axis: one decompressed byte per transaction; tlast marks the final byte of
// a command, tuser flags a match with a zero or out-of-range offset (one
// transaction, data zero).
// A literal passes from acceptance through the command queue and the output register.
// A match chunk of L bytes occupies the copy unit: each byte takes a history RAM read
// state (ST_READ) and then a write/emit state (ST_WRITE), since the next read may hit the byte just
// written. Literals, errors and block starts sustain one per cycle while no copy runs and m_axis accepts.
// A 4-entry command queue sits between the classifier and the copy unit, so
// s_axis keeps accepting while a copy runs or m_axis stalls, until it fills.
// When m_axis stalls, the output register holds and the copy unit waits.
// Reset clears the produced count, write position, queue and output valid;
// history content is undefined until written and needs no clearing pass.
module lz4_match_copy_engine
    import lzmc_pkg::*;
#(
    parameter int WINDOW    = 65536,
    parameter int MAX_CHUNK = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // literal_byte[7:0], match_offset[23:8], chunk_len[30:24]
    input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // out_byte[7:0]
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser   // error[0]
);

    cmd_push_t push;
    logic      q_full;
    logic      q_empty;
    logic      q_pop;
    cmd_t      q_head;

    lzmc_front #(
        .WINDOW    (WINDOW),
        .MAX_CHUNK (MAX_CHUNK)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .req_type     (s_axis_tuser),
        .literal_byte (s_axis_tdata[7:0]),
        .match_offset (s_axis_tdata[23:8]),
        .chunk_len    (s_axis_tdata[30:24]),
        .q_full       (q_full),
        .push         (push)
    );

    lzmc_fifo u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .head  (q_head)
    );

    lzmc_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_error (m_axis_tuser[0])
    );

endmodule

FILE: sv/lzmc_checker.sv
`timescale 1ns / 1ps

module lzmc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic [0:0] m_axis_tuser
);

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("error transaction without tlast");

    a_err_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 8'd0)
        else $error("error transaction with nonzero data");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled output transaction changed");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output valid during reset");

endmodule

bind lz4_match_copy_engine lzmc_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: dv/lz4_match_copy_engine_test.sv
`timescale 1ns / 1ps

module lz4_match_copy_engine_test;
    import lzmc_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED  = 2'd3;
    localparam int               HIST_DEPTH  = 65536;
    localparam logic [LEN_W-1:0] CHUNK_MAX   = 7'd64;
    localparam int               CYCLE_LIMIT = 4_000_000;
    localparam int               MAX_REPORTS = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              tlast;
        logic              err;
    } out_beat_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;
    logic [1:0]        s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;
    logic              m_axis_tlast;
    logic [0:0]        m_axis_tuser;

    logic [BYTE_W-1:0] hist_mem [0:HIST_DEPTH-1];
    logic [OFF_W-1:0]  wr_ptr = '0;
    logic [PROD_W-1:0] byte_count = '0;
    out_beat_t         beat_q[$];

    int                fail_count = 0;
    int                cycle_count = 0;
    int                burst_left = 0;
    bit                valid_held = 1'b0;
    int                rx_tick = 0;
    int                rx_mode = 0;
    out_beat_t         got_beat;
    out_beat_t         exp_beat;

    lz4_match_copy_engine u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("lz4_match_copy_engine verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rx_tick++;
        if (rx_tick % 48 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (rx_tick % 4 == 0);
            default: m_axis_tready <= (rx_tick % 5 >= 2);
        endcase
    end

    function automatic void append_byte(input logic [BYTE_W-1:0] b, input logic is_last);
        out_beat_t beat;
        hist_mem[wr_ptr] = b;
        wr_ptr = wr_ptr + OFF_W'(1);
        if (byte_count != PROD_MAX)
            byte_count = byte_count + PROD_W'(1);
        beat.data  = b;
        beat.tlast = is_last;
        beat.err   = 1'b0;
        beat_q.push_back(beat);
    endfunction

    function automatic void predict_cmd(input logic [REQ_W-1:0] kind,
                                        input logic [BYTE_W-1:0] lit,
                                        input logic [OFF_W-1:0] off,
                                        input logic [LEN_W-1:0] len);
        int        n;
        out_beat_t beat;
        case (kind)
            REQ_BLOCK: byte_count = '0;
            REQ_LITERAL: append_byte(lit, 1'b1);
            REQ_MATCH:
            begin
                if (len != '0)
                begin
                    n = int'((len > CHUNK_MAX) ? CHUNK_MAX : len);
                    if (off == '0 || PROD_W'(off) > byte_count)
                    begin
                        beat.data  = '0;
                        beat.tlast = 1'b1;
                        beat.err   = 1'b1;
                        beat_q.push_back(beat);
                    end
                    else
                    begin
                        for (int i = 0; i < n; i++)
                            append_byte(hist_mem[OFF_W'(wr_ptr - off)], i == n - 1);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_beat.data  = m_axis_tdata;
            got_beat.tlast = m_axis_tlast;
            got_beat.err   = m_axis_tuser[0];
            if (beat_q.size() == 0)
            begin
                if (fail_count < MAX_REPORTS)
                    $display("unexpected output transaction: data %02h last %0b err %0b",
                             got_beat.data, got_beat.tlast, got_beat.err);
                fail_count++;
            end
            else
            begin
                exp_beat = beat_q.pop_front();
                if (got_beat !== exp_beat)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display({"mismatch: expected data %02h last %0b err %0b, ",
                                  "got data %02h last %0b err %0b"},
                                 exp_beat.data, exp_beat.tlast, exp_beat.err,
                                 got_beat.data, got_beat.tlast, got_beat.err);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_cmd(input logic [REQ_W-1:0] kind,
                            input logic [BYTE_W-1:0] lit,
                            input logic [OFF_W-1:0] off,
                            input logic [LEN_W-1:0] len);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, len, off, lit};
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_cmd(kind, lit, off, len);
        valid_held = 1'b1;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                valid_held = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic release_input();
        if (valid_held)
        begin
            s_axis_tvalid <= 1'b0;
            valid_held = 1'b0;
        end
    endtask

    task automatic test_directed();
        send_cmd(REQ_UNUSED,  8'hFF, 16'hFFFF, 7'h7F);
        send_cmd(REQ_MATCH,   8'h00, 16'd1,    7'd1);
        send_cmd(REQ_MATCH,   8'h00, 16'd0,    7'd0);
        send_cmd(REQ_LITERAL, 8'h00, 16'd0,    7'd0);
        send_cmd(REQ_LITERAL, 8'hFF, 16'hFFFF, 7'h7F);
        send_cmd(REQ_LITERAL, 8'hA5, 16'd0,    7'd0);
        send_cmd(REQ_MATCH,   8'h00, 16'd0,    7'd5);
        send_cmd(REQ_MATCH,   8'h00, 16'd4,    7'd3);
        send_cmd(REQ_MATCH,   8'h00, 16'd3,    7'd3);
        send_cmd(REQ_MATCH,   8'h00, 16'd1,    7'd10);
        send_cmd(REQ_MATCH,   8'hFF, 16'd2,    7'h7F);
        send_cmd(REQ_MATCH,   8'h00, 16'hFFFF, 7'd64);
        send_cmd(REQ_MATCH,   8'h00, 16'd7,    7'd65);
        send_cmd(REQ_BLOCK,   8'h00, 16'd0,    7'd0);
        send_cmd(REQ_MATCH,   8'h00, 16'd1,    7'd1);
        send_cmd(REQ_LITERAL, 8'h5A, 16'd0,    7'd0);
        send_cmd(REQ_MATCH,   8'h00, 16'd1,    7'd64);
        send_cmd(REQ_MATCH,   8'h00, 16'd65,   7'd2);
        send_cmd(REQ_MATCH,   8'h00, 16'd68,   7'd1);
        send_cmd(REQ_BLOCK,   8'hFF, 16'hFFFF, 7'h7F);
        send_cmd(REQ_BLOCK,   8'h00, 16'd0,    7'd0);
        send_cmd(REQ_LITERAL, 8'h3C, 16'd0,    7'd0);
        release_input();
    endtask

    task automatic test_random_sequences(input int n_items);
        int                done;
        int                pick;
        int                max_off;
        logic [REQ_W-1:0]  kind;
        logic [BYTE_W-1:0] lit;
        logic [OFF_W-1:0]  off;
        logic [LEN_W-1:0]  len;
        done = 0;
        while (done < n_items)
        begin
            pick    = $urandom_range(0, 99);
            lit     = BYTE_W'($urandom);
            off     = OFF_W'($urandom);
            len     = LEN_W'($urandom_range(1, 16));
            max_off = (byte_count > PROD_W'(65535)) ? 65535 : int'(byte_count);
            if (pick < 4)
                kind = REQ_BLOCK;
            else if (pick < 40)
                kind = REQ_LITERAL;
            else if (pick < 88)
            begin
                kind = REQ_MATCH;
                if (max_off == 0)
                    off = OFF_W'($urandom_range(0, 3));
                else if ($urandom_range(0, 1) == 0)
                    off = OFF_W'($urandom_range(1, (max_off < 16) ? max_off : 16));
                else
                    off = OFF_W'($urandom_range(1, max_off));
                if ($urandom_range(0, 9) == 0)
                    len = LEN_W'($urandom_range(17, 127));
            end
            else if (pick < 93)
            begin
                kind = REQ_MATCH;
                len  = LEN_W'($urandom);
            end
            else if (pick < 96)
            begin
                kind = REQ_MATCH;
                off  = '0;
            end
            else
                kind = REQ_UNUSED;
            if (!(kind == REQ_UNUSED || (kind == REQ_MATCH && len == '0)))
                done++;
            send_cmd(kind, lit, off, len);
        end
        release_input();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_sequences(200);
        while (beat_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0 && beat_q.size() == 0)
            $display("lz4_match_copy_engine verification clean");
        else
            $display("lz4_match_copy_engine verification failed");
        $finish;
    end

endmodule
